// ----- sv/assert_macros.svh -----
// assertion macros shared by the keyword matcher rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication, sampled on the rising clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/ckm_pkg.sv -----
// types, constants and character helpers for the keyword matcher
// no dependencies; imported by every module of the block but ckm_ram
`timescale 1ns / 1ps
`default_nettype none

package ckm_pkg;

    // fixed field widths
    localparam int CHAR_W  = 8;
    localparam int ENTRY_W = 5;
    localparam int POS_W   = 5;
    localparam int IDX_W   = 5;
    localparam int CFG_W   = 6;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    // input commands
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_LINE    = 1'b1;

    // register indexes (address bit 2)
    localparam logic REG_ENTRY_COUNT   = 1'b0;
    localparam logic REG_COMPARE_LIMIT = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] ENTRY_COUNT_RST   = 6'd0;
    localparam logic [CFG_W-1:0] COMPARE_LIMIT_RST = 6'd32;

    // search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRD,
        S_PCHK,
        S_LRD,
        S_LCHK,
        S_DONE
    } seq_state_t;

    // flags from the shared compare unit
    typedef struct packed {
        logic p_space;
        logic c_space;
        logic p_end;
        logic p_tilde;
        logic fold_eq;
    } cmp_t;

    // line end request to the sequencer
    typedef struct packed {
        logic go;
        logic overflowed;
    } start_t;

    // sequencer status back to the top level
    typedef struct packed {
        logic busy;
        logic done_valid;
    } seq_status_t;

    // one result transfer
    typedef struct packed {
        logic             matched;
        logic [IDX_W-1:0] entry_index;
        logic             overflow;
    } result_t;

    // fold A-Z to lower case
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] r;
        r = ch;
        if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z)
        begin
            r = ch + CASE_DIFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ckm_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies; used for the pattern store and the line store
`timescale 1ns / 1ps
`default_nettype none

module ckm_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/ckm_cmp.sv -----
// shared character compare unit: space, terminator and case-folded equality
// depends on ckm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ckm_cmp (
    input  wire logic [ckm_pkg::CHAR_W-1:0] p,
    input  wire logic [ckm_pkg::CHAR_W-1:0] c,
    output ckm_pkg::cmp_t                   flags
);
    import ckm_pkg::*;

    // pattern and line character classes, folded compare
    always_comb
    begin
        flags.p_space = (fold(p) == CHAR_SPACE);
        flags.c_space = (fold(c) == CHAR_SPACE);
        flags.p_end   = (p == CHAR_NUL);
        flags.p_tilde = (p == CHAR_TILDE);
        flags.fold_eq = (fold(p) == fold(c));
    end

endmodule

`default_nettype wire

// ----- sv/ckm_seq.sv -----
// search sequencer: walks the pattern table one character at a time
// depends on ckm_pkg, ckm_cmp and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ckm_seq #(
    parameter int  MAX_ENTRIES = 32,
    parameter int  PATTERN_LEN = 32,
    parameter int  LINE_LEN    = 32,
    localparam int PAW = $clog2(MAX_ENTRIES * PATTERN_LEN),
    localparam int LIW = $clog2(LINE_LEN),
    localparam int LLW = $clog2(LINE_LEN + 1),
    localparam int EW  = $clog2(MAX_ENTRIES + 1),
    localparam int PIW = $clog2(PATTERN_LEN + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  ckm_pkg::start_t                     start,
    input  wire logic [LLW-1:0]                 line_len,
    input  wire logic [EW-1:0]                  count,
    input  wire logic [PIW-1:0]                 limit,
    input  wire logic                           ack,
    output ckm_pkg::seq_status_t                status,
    output ckm_pkg::result_t                    result,
    output logic      [PAW-1:0]                 pat_raddr,
    input  wire logic [ckm_pkg::CHAR_W-1:0]     pat_rdata,
    output logic      [LIW-1:0]                 line_raddr,
    input  wire logic [ckm_pkg::CHAR_W-1:0]     line_rdata
);
    import ckm_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [EW-1:0]     e_reg, e_next;
    logic [PAW-1:0]    base_reg, base_next;
    logic [PIW-1:0]    i_reg, i_next;
    logic [LLW-1:0]    b_reg, b_next;
    logic [LLW-1:0]    len_reg, len_next;
    logic [CHAR_W-1:0] p_reg, p_next;
    result_t           res_reg, res_next;

    logic [CHAR_W-1:0] p_in;
    cmp_t              flags;
    logic              have_c, skip, term, hit, step, fail_p, fail_l, last_entry;

    // compare unit sees the fresh pattern read in PCHK, the held one after
    assign p_in = (state_reg == S_PCHK) ? pat_rdata : p_reg;

    ckm_cmp u_cmp (
        .p     (p_in),
        .c     (line_rdata),
        .flags (flags)
    );

    // step decisions
    always_comb
    begin
        have_c     = (b_reg < len_reg);
        skip       = have_c && flags.c_space;
        term       = flags.p_end || flags.p_tilde;
        hit        = !skip && term && (flags.p_tilde || !have_c);
        step       = !skip && !term && have_c && flags.fold_eq;
        fail_l     = !skip && !hit && !step;
        fail_p     = (i_reg == limit);
        last_entry = (({1'b0, e_reg} + (EW + 1)'(1)) == {1'b0, count});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start.go)
                begin
                    if (start.overflowed || count == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                if (fail_p)
                    state_next = last_entry ? S_DONE : S_PRD;
                else
                    state_next = S_PCHK;
            end
            S_PCHK:
            begin
                state_next = flags.p_space ? S_PRD : S_LRD;
            end
            S_LRD:
            begin
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                if (skip)
                    state_next = S_LRD;
                else if (hit)
                    state_next = S_DONE;
                else if (step)
                    state_next = S_PRD;
                else
                    state_next = last_entry ? S_DONE : S_PRD;
            end
            S_DONE:
            begin
                if (ack)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        status.busy       = (state_reg != S_IDLE);
        status.done_valid = (state_reg == S_DONE);
        result            = res_reg;
        pat_raddr         = base_reg + PAW'(i_reg);
        line_raddr        = b_reg[LIW-1:0];
    end

    // datapath next values
    always_comb
    begin
        e_next    = e_reg;
        base_next = base_reg;
        i_next    = i_reg;
        b_next    = b_reg;
        len_next  = len_reg;
        p_next    = p_reg;
        res_next  = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start.go)
                begin
                    e_next               = '0;
                    base_next            = '0;
                    i_next               = '0;
                    b_next               = '0;
                    len_next             = line_len;
                    res_next.matched     = 1'b0;
                    res_next.entry_index = '0;
                    res_next.overflow    = start.overflowed;
                end
            end
            S_PRD:
            begin
                // examined positions used up: move to the next entry
                if (fail_p)
                begin
                    e_next    = e_reg + EW'(1);
                    base_next = base_reg + PAW'(PATTERN_LEN);
                    i_next    = '0;
                    b_next    = '0;
                end
            end
            S_PCHK:
            begin
                p_next = pat_rdata;
                if (flags.p_space)
                    i_next = i_reg + PIW'(1);
            end
            S_LRD:
            begin
                p_next = p_reg;
            end
            S_LCHK:
            begin
                if (skip)
                begin
                    b_next = b_reg + LLW'(1);
                end
                else if (hit)
                begin
                    res_next.matched     = 1'b1;
                    res_next.entry_index = IDX_W'(e_reg);
                end
                else if (step)
                begin
                    b_next = b_reg + LLW'(1);
                    i_next = i_reg + PIW'(1);
                end
                else
                begin
                    e_next    = e_reg + EW'(1);
                    base_next = base_reg + PAW'(PATTERN_LEN);
                    i_next    = '0;
                    b_next    = '0;
                end
            end
            S_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            b_reg     <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            b_reg     <= b_next;
            len_reg   <= len_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        base_reg <= base_next;
        p_reg    <= p_next;
        res_reg  <= res_next;
    end

    // position and line cursors stay in range while searching
    `ASSERT_IMPL(a_pos_bound, clk, rst_n, state_reg != S_IDLE, i_reg <= limit)
    `ASSERT_IMPL(a_line_bound, clk, rst_n, state_reg != S_IDLE, b_reg <= len_reg)
    // an overflowed line never reports a match
    `ASSERT_IMPL(a_ovf_nomatch, clk, rst_n, status.done_valid && res_reg.overflow, !res_reg.matched)
    // a finished result waits unchanged until taken
    `ASSERT_NEXT(a_done_hold, clk, rst_n, status.done_valid && !ack, status.done_valid && $stable(res_reg))

endmodule

`default_nettype wire

// ----- sv/command_keyword_matcher.sv -----
// command keyword matcher: config registers, line gathering, result register
// depends on ckm_pkg, ckm_ram and ckm_seq
//
// Usage
//   Input channel (in_valid/in_stall): command 0 writes char_code into the
//   pattern table at entry/position, command 1 receives one line character.
//   Pattern writes and non-zero line characters give no result. A zero line
//   character ends the line and starts the table search.
//   Search: each examined pattern position is read from the pattern store
//   (PRD, PCHK) and, when it is not a space, the line character is then read
//   from the line store (LRD, LCHK); each skipped line space repeats the line
//   store read. An overflowed line or entry_count of zero goes straight to
//   the result. The single pattern store read port and line store read port
//   make the search walk one position at a time.
//   in_stall stays high from the line end transfer until its result moves
//   to the output register.
//   Output channel (out_valid/out_stall): one transfer per line with matched,
//   entry_index and overflow; it holds while out_stall is high, and the
//   search result waits in the sequencer meanwhile.
//   Reset clears the line, overflow flag, registers (entry_count 0,
//   compare_limit 32) and the output; pattern contents survive undefined. The
//   user writes registers over APB at 0x0 and 0x4 only while idle, unchecked.
`timescale 1ns / 1ps
`default_nettype none

module command_keyword_matcher #(
    parameter int MAX_ENTRIES = 32,
    parameter int PATTERN_LEN = 32,
    parameter int LINE_LEN    = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // apb configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ckm_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ckm_pkg::DATA_W-1:0]    pwdata,
    output logic      [ckm_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic [ckm_pkg::ENTRY_W-1:0]   entry,
    input  wire logic [ckm_pkg::POS_W-1:0]     position,
    input  wire logic [ckm_pkg::CHAR_W-1:0]    char_code,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               matched,
    output logic      [ckm_pkg::IDX_W-1:0]     entry_index,
    output logic                               overflow
);
    import ckm_pkg::*;

    localparam int PAW = $clog2(MAX_ENTRIES * PATTERN_LEN);
    localparam int LIW = $clog2(LINE_LEN);
    localparam int LLW = $clog2(LINE_LEN + 1);
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int PIW = $clog2(PATTERN_LEN + 1);

    logic [CFG_W-1:0] entry_count_reg, entry_count_next;
    logic [CFG_W-1:0] compare_limit_reg, compare_limit_next;
    logic [LLW-1:0]   line_len_reg, line_len_next;
    logic             line_ovf_reg, line_ovf_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg;

    logic             cfg_we, in_xfer, pat_we, line_we, line_room;
    logic [PAW-1:0]   pat_waddr, pat_raddr;
    logic [LIW-1:0]   line_raddr;
    logic [CHAR_W-1:0] pat_rdata, line_rdata;
    logic [EW-1:0]    count;
    logic [PIW-1:0]   limit;
    logic             slot_free, ack;
    start_t           start;
    seq_status_t      status;
    result_t          seq_res;

    // configuration writes and reads
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        entry_count_next   = entry_count_reg;
        compare_limit_next = compare_limit_reg;
        prdata             = '0;
        unique case (paddr[2])
            REG_ENTRY_COUNT:
            begin
                prdata = DATA_W'(entry_count_reg);
                if (cfg_we)
                    entry_count_next = pwdata[CFG_W-1:0];
            end
            REG_COMPARE_LIMIT:
            begin
                prdata = DATA_W'(compare_limit_reg);
                if (cfg_we)
                    compare_limit_next = pwdata[CFG_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // clamp the registers to the table size
    always_comb
    begin
        if (int'(entry_count_reg) > MAX_ENTRIES)
            count = EW'(MAX_ENTRIES);
        else
            count = EW'(entry_count_reg);
        if (int'(compare_limit_reg) > PATTERN_LEN)
            limit = PIW'(PATTERN_LEN);
        else
            limit = PIW'(compare_limit_reg);
    end

    // input transfer decode
    always_comb
    begin
        in_xfer   = in_valid && !in_stall;
        pat_we    = in_xfer && (command == CMD_PATTERN)
                    && (int'(entry) < MAX_ENTRIES) && (int'(position) < PATTERN_LEN);
        pat_waddr = PAW'(int'(entry) * PATTERN_LEN + int'(position));
        line_room = (line_len_reg < LLW'(LINE_LEN));
        line_we   = in_xfer && (command == CMD_LINE) && (char_code != CHAR_NUL)
                    && line_room;
        start.go         = in_xfer && (command == CMD_LINE) && (char_code == CHAR_NUL);
        start.overflowed = line_ovf_reg;
    end

    // line length and overflow flag
    always_comb
    begin
        line_len_next = line_len_reg;
        line_ovf_next = line_ovf_reg;
        if (start.go)
        begin
            line_len_next = '0;
            line_ovf_next = 1'b0;
        end
        else if (line_we)
        begin
            line_len_next = line_len_reg + LLW'(1);
        end
        else if (in_xfer && (command == CMD_LINE) && !line_room)
        begin
            line_ovf_next = 1'b1;
        end
    end

    // pattern table
    ckm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_ENTRIES * PATTERN_LEN)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (char_code),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    // received line
    ckm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_len_reg[LIW-1:0]),
        .wdata (char_code),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // table search
    ckm_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PATTERN_LEN (PATTERN_LEN),
        .LINE_LEN    (LINE_LEN)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .line_len   (line_len_reg),
        .count      (count),
        .limit      (limit),
        .ack        (ack),
        .status     (status),
        .result     (seq_res),
        .pat_raddr  (pat_raddr),
        .pat_rdata  (pat_rdata),
        .line_raddr (line_raddr),
        .line_rdata (line_rdata)
    );

    assign in_stall = status.busy;

    // output register handoff
    always_comb
    begin
        slot_free      = !out_valid_reg || !out_stall;
        ack            = status.done_valid && slot_free;
        out_valid_next = ack || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg   <= ENTRY_COUNT_RST;
            compare_limit_reg <= COMPARE_LIMIT_RST;
            line_len_reg      <= '0;
            line_ovf_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            entry_count_reg   <= entry_count_next;
            compare_limit_reg <= compare_limit_next;
            line_len_reg      <= line_len_next;
            line_ovf_reg      <= line_ovf_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign matched     = out_res_reg.matched;
    assign entry_index = out_res_reg.entry_index;
    assign overflow    = out_res_reg.overflow;

endmodule

`default_nettype wire
